@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the RTL core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition holds at every rising edge of clk outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	`ASSERT_CLK(label, 1'b1 |-> (cond), msg)

`endif

@@ rtl/bcdt_pkg.sv @@
// ----------------------------------------------------------------------------
// bcdt_pkg
// Types, key codes and the seven-segment table of the BCD countdown timer.
// ----------------------------------------------------------------------------
package bcdt_pkg;

	typedef logic [3:0]      digit_t;
	// index 0 = thousands, index 3 = units
	typedef digit_t [3:0]    digits_t;
	typedef logic [2:0]      slot_t;
	typedef logic [2:0]      entry_t;

	typedef struct packed {
		digits_t digits;
		logic    run;
		entry_t  entry;
		logic    expired;
	} tmr_next_t;

	localparam logic [4:0]  KEY_DIGIT_MAX = 5'd9;
	localparam logic [4:0]  KEY_CLEAR     = 5'd10;
	localparam logic [4:0]  KEY_TOGGLE    = 5'd16;
	localparam logic [4:0]  KEY_LOAD3     = 5'd17;

	localparam logic        MODE_TICK     = 1'b0;
	localparam logic        MODE_KEY      = 1'b1;

	localparam entry_t      ENTRY_MAX     = 3'd4;
	localparam slot_t       SCAN_SLOTS    = 3'd4;
	localparam logic [15:0] TPS_RESET     = 16'd1000;
	localparam logic [7:0]  SEL_NONE      = 8'hFF;
	localparam logic [7:0]  SEG_BLANK     = 8'h00;
	localparam digit_t      DIGIT_NINE    = 4'd9;
	localparam digit_t      DIGIT_THREE   = 4'd3;

	function automatic logic [7:0] seg_decode(input digit_t d);
		logic [7:0] p;
		begin
			unique case (d)
				4'd0:    p = 8'h3F;
				4'd1:    p = 8'h06;
				4'd2:    p = 8'h5B;
				4'd3:    p = 8'h4F;
				4'd4:    p = 8'h66;
				4'd5:    p = 8'h6D;
				4'd6:    p = 8'h7D;
				4'd7:    p = 8'h07;
				4'd8:    p = 8'h7F;
				4'd9:    p = 8'h6F;
				default: p = SEG_BLANK;
			endcase
			return p;
		end
	endfunction

endpackage

@@ rtl/bcdt_timer.sv @@
// ----------------------------------------------------------------------------
// bcdt_timer
// Count digits, entry count, run flag and prescaler with their next-state logic.
// ----------------------------------------------------------------------------
module bcdt_timer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               mode,
	input  logic [4:0]         key_code,
	input  logic [15:0]        tps,
	output bcdt_pkg::tmr_next_t nxt
);
	import bcdt_pkg::*;

	digits_t     digits_q;
	entry_t      entry_q;
	logic        run_q;
	logic [15:0] pre_q;

	digits_t     dec;
	logic        all_zero;
	logic [15:0] pre_inc;
	digits_t     digits_d;
	entry_t      entry_d;
	logic        run_d;
	logic [15:0] pre_d;
	logic        expired;

	// one-second decrement with decimal borrow
	always_comb begin
		dec      = digits_q;
		all_zero = 1'b1;
		for (int k = 3; k >= 0; k--) begin
			if (all_zero) begin
				if (digits_q[k] != '0) begin
					dec[k]   = digits_q[k] - 4'd1;
					all_zero = 1'b0;
				end else begin
					dec[k] = DIGIT_NINE;
				end
			end
		end
	end

	assign pre_inc = pre_q + 16'd1;

	always_comb begin
		digits_d = digits_q;
		entry_d  = entry_q;
		run_d    = run_q;
		pre_d    = pre_q;
		expired  = 1'b0;
		if (mode == MODE_KEY) begin
			if (key_code <= KEY_DIGIT_MAX && entry_q < ENTRY_MAX) begin
				digits_d[0] = digits_q[1];
				digits_d[1] = digits_q[2];
				digits_d[2] = digits_q[3];
				digits_d[3] = key_code[3:0];
				entry_d     = entry_q + 3'd1;
			end else if (key_code == KEY_CLEAR) begin
				digits_d = '0;
				entry_d  = '0;
			end else if (key_code == KEY_TOGGLE) begin
				run_d = ~run_q;
			end
			if (key_code == KEY_LOAD3) begin
				digits_d    = '0;
				digits_d[3] = DIGIT_THREE;
			end
		end else if (run_q) begin
			pre_d = pre_inc;
			if (pre_inc >= tps) begin
				pre_d = '0;
				if (all_zero) begin
					expired  = 1'b1;
					run_d    = 1'b0;
					digits_d = '0;
					entry_d  = '0;
				end else begin
					digits_d = dec;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= '0;
			entry_q  <= '0;
			run_q    <= 1'b0;
			pre_q    <= '0;
		end else if (adv) begin
			digits_q <= digits_d;
			entry_q  <= entry_d;
			run_q    <= run_d;
			pre_q    <= pre_d;
		end
	end

	assign nxt.digits  = digits_d;
	assign nxt.run     = run_d;
	assign nxt.entry   = entry_d;
	assign nxt.expired = expired;

endmodule

@@ rtl/bcdt_scan.sv @@
// ----------------------------------------------------------------------------
// bcdt_scan
// Five-slot display scan: slot counter and segment/select generation.
// ----------------------------------------------------------------------------
module bcdt_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                mode,
	input  bcdt_pkg::tmr_next_t nxt,
	output logic [7:0]          pattern,
	output logic [7:0]          select,
	output logic                strobe
);
	import bcdt_pkg::*;

	slot_t slot_q;
	logic  drive;

	assign drive = (mode == MODE_TICK) && !nxt.expired && (slot_q < SCAN_SLOTS);

	always_comb begin
		pattern = SEG_BLANK;
		select  = SEL_NONE;
		strobe  = 1'b0;
		if (drive) begin
			pattern = seg_decode(nxt.digits[slot_q[1:0]]);
			select  = ~(8'd1 << slot_q);
			strobe  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (adv && mode == MODE_TICK) begin
			if (drive) begin
				slot_q <= slot_q + 3'd1;
			end else begin
				slot_q <= '0;
			end
		end
	end

endmodule

@@ rtl/bcd_countdown_timer_with_entry_core.sv @@
// ----------------------------------------------------------------------------
// bcd_countdown_timer_with_entry_core
// Four-digit BCD countdown timer with keypad entry and display scan.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one item (mode, key_code). mode 1 is
// a key press, mode 0 a one-millisecond tick. Output channel: out_valid/
// out_stall carry one result per item: the four count digits, running,
// entered_count and the scanned display digit (segment_pattern,
// digit_select, display_strobe).
// Configuration: cfg_valid/cfg_ready write tick_per_second (cfg_data);
// cfg_ready is always high. Write it only while no item is in flight.
// Path: an accepted item sits in the input register and moves into the result
// register once out_stall is not holding the result there; out_valid then
// rises with the new result in the result register.
// Throughput: one item per cycle unless out_stall holds a result; the state
// update is a single pass of shallow logic between the input and result registers.
// Stall: while out_stall holds a result, the input register keeps its item
// and in_stall rises once that register is full.
// Reset: tick_per_second returns to 1000, digits to 0000, the timer stops,
// entry count, prescaler and scan slot clear; both registers empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcd_countdown_timer_with_entry_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [4:0]  key_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  digit_thousands,
	output logic [3:0]  digit_hundreds,
	output logic [3:0]  digit_tens,
	output logic [3:0]  digit_units,
	output logic        running,
	output logic [2:0]  entered_count,
	output logic [7:0]  segment_pattern,
	output logic [7:0]  digit_select,
	output logic        display_strobe
);
	import bcdt_pkg::*;

	logic [15:0] tps_q;
	logic        valid_s1;
	logic        mode_s1;
	logic [4:0]  key_s1;
	logic        out_valid_q;
	logic        adv;
	logic        load_s1;
	tmr_next_t   nxt;
	logic [7:0]  pattern;
	logic [7:0]  select;
	logic        strobe;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tps_q <= cfg_data;
		end
	end

	// advance the input stage into the result register
	assign adv      = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			mode_s1 <= mode;
			key_s1  <= key_code;
		end
	end

	bcdt_timer u_timer (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.mode     (mode_s1),
		.key_code (key_s1),
		.tps      (tps_q),
		.nxt      (nxt)
	);

	bcdt_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.mode    (mode_s1),
		.nxt     (nxt),
		.pattern (pattern),
		.select  (select),
		.strobe  (strobe)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			digit_thousands <= nxt.digits[0];
			digit_hundreds  <= nxt.digits[1];
			digit_tens      <= nxt.digits[2];
			digit_units     <= nxt.digits[3];
			running         <= nxt.run;
			entered_count   <= nxt.entry;
			segment_pattern <= pattern;
			digit_select    <= select;
			display_strobe  <= strobe;
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_CLK(a_stall_cause, in_stall |-> (valid_s1 && out_valid_q && out_stall), "in_stall without a held result")
	`ASSERT_CLK(a_strobe_select, (out_valid && display_strobe) |-> ($countones(digit_select) == 7), "strobe without one selected position")
	`ASSERT_CLK(a_idle_display, (out_valid && !display_strobe) |-> (segment_pattern == SEG_BLANK && digit_select == SEL_NONE), "undriven slot shows segments")
	`ASSERT_ALWAYS(a_entry_range, !out_valid || entered_count <= ENTRY_MAX, "entered_count above four")

endmodule
